// File: hw/rtl/fufla_pkg.sv
// ----------------------------------------------------------------------------
// fufla_pkg
// shared types, codes and defaults of the fixed-unit free-list allocator
// ----------------------------------------------------------------------------
package fufla_pkg;

  // default number of units in the pool
  localparam int unsigned UNIT_COUNT_DEF = 256;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // register reset values
  localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd6;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SIZE_LOG2 = 2'd1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED  = 3'd0,
    ST_TOO_LARGE  = 3'd1,
    ST_POOL_EMPTY = 3'd2,
    ST_FREED      = 3'd3,
    ST_OUTSIDE    = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;   // write one entry of the link table reset pattern
    logic accept;   // capture an input beat
    logic commit;   // execute the captured request and load the result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last; // clearing pass is at the last entry
    logic out_free; // result register can take a new beat
  } dp_sts_t;

endpackage

// File: hw/rtl/fixed_unit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_unit_free_list_allocator
// pool of equal power-of-two units handed out and taken back through a
// lifo free list held in a link table
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | beat contents
//  ---------+-----------------------+------------------------------------------
//  in_      | in_valid / in_ready   | in_op, in_request_size, in_free_address
//  out_     | out_valid / out_ready | out_status, out_unit_address
//  cfg_     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
//  each request first takes the beat and reads the link of the current head from
//  the link table ram, then updates head and table in execute
//  the ram read is registered, and the next request needs the new head
//  after reset a clearing pass writes every entry of the link table with
//  in_ready low; config writes are taken during it
//  a result waiting in the output register does not block the next beat; the
//  request after it waits in execute until the output register is free
//
module fixed_unit_free_list_allocator import fufla_pkg::*; #(
  parameter int unsigned UNIT_COUNT = UNIT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  // request beats
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [SIZE_W-1:0]     in_request_size,
  input  logic [ADDR_W-1:0]     in_free_address,

  // result beats
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ADDR_W-1:0]     out_unit_address,

  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // registers can always be written, unknown indexes fall through in the datapath
  assign cfg_ready = 1'b1;

  // sequencing: clear pass, take beat, execute
  fufla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // head, link table, address math and result register
  fufla_dpath #(
    .UNIT_COUNT (UNIT_COUNT)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_op            (in_op),
    .in_request_size  (in_request_size),
    .in_free_address  (in_free_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_unit_address (out_unit_address)
  );

endmodule

// File: hw/rtl/fufla_ram.sv
// ----------------------------------------------------------------------------
// fufla_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module fufla_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/fufla_dpath.sv
// ----------------------------------------------------------------------------
// fufla_dpath
// allocator datapath: config registers, free-list head, link table,
// address arithmetic and the result register
// ----------------------------------------------------------------------------
module fufla_dpath import fufla_pkg::*; #(
  parameter int unsigned UNIT_COUNT = UNIT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_op,
  input  logic [SIZE_W-1:0]     in_request_size,
  input  logic [ADDR_W-1:0]     in_free_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ADDR_W-1:0]     out_unit_address
);

  localparam int unsigned IDX_W = $clog2(UNIT_COUNT);
  localparam int unsigned LNK_W = $clog2(UNIT_COUNT + 1);
  localparam logic [LNK_W-1:0] EMPTY_LNK = LNK_W'(UNIT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(UNIT_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_IDX_W = ADDR_W'(UNIT_COUNT - 1);

  logic [ADDR_W-1:0]   base_r;
  logic [SHIFT_W-1:0]  shift_r;
  logic [LNK_W-1:0]    head_r,  head_nxt;
  logic [IDX_W-1:0]    clr_cnt_r;
  logic                op_r;
  logic [SIZE_W-1:0]   size_r;
  logic [ADDR_W:0]     diff_r;     // free address minus base, msb is borrow
  logic                out_valid_r;
  status_t             status_r,  status_nxt;
  logic [ADDR_W-1:0]   uaddr_r,   uaddr_nxt;

  logic                ram_wr;
  logic [IDX_W-1:0]    ram_wr_addr;
  logic [LNK_W-1:0]    ram_wr_data;
  logic [LNK_W-1:0]    ram_rd_data;

  logic [SIZE_W:0]     unit_bytes;
  logic                too_big;
  logic                pool_empty;
  logic [ADDR_W-1:0]   alloc_addr;
  logic [ADDR_W-1:0]   free_idx_full;
  logic [ADDR_W-1:0]   off_mask;
  logic                in_pool;
  logic                free_wr;

  // link table, read port always follows the head
  fufla_ram #(
    .WIDTH (LNK_W),
    .DEPTH (UNIT_COUNT)
  ) u_link (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (head_r[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // request evaluation
  always_comb begin
    unit_bytes    = (SIZE_W+1)'(1) << shift_r;
    too_big       = {1'b0, size_r} > unit_bytes;
    pool_empty    = head_r == EMPTY_LNK;
    alloc_addr    = base_r + (ADDR_W'(head_r) << shift_r);
    free_idx_full = diff_r[ADDR_W-1:0] >> shift_r;
    off_mask      = ~({ADDR_W{1'b1}} << shift_r);
    // in the last unit only its first byte is inside the pool
    in_pool       = !diff_r[ADDR_W] && ((free_idx_full < LAST_IDX_W) ||
                    ((free_idx_full == LAST_IDX_W) &&
                     ((diff_r[ADDR_W-1:0] & off_mask) == '0)));

    head_nxt   = head_r;
    status_nxt = ST_ALLOCATED;
    uaddr_nxt  = '0;
    free_wr    = 1'b0;
    if (op_r == OP_ALLOC) begin
      if (too_big) begin
        status_nxt = ST_TOO_LARGE;
      end else if (pool_empty) begin
        status_nxt = ST_POOL_EMPTY;
      end else begin
        status_nxt = ST_ALLOCATED;
        uaddr_nxt  = alloc_addr;
        head_nxt   = ram_rd_data;
      end
    end else begin
      if (in_pool) begin
        status_nxt = ST_FREED;
        free_wr    = 1'b1;
        head_nxt   = LNK_W'(free_idx_full[IDX_W-1:0]);
      end else begin
        status_nxt = ST_OUTSIDE;
      end
    end
  end

  // clearing pass has the write port to itself
  always_comb begin
    if (cmd.clr_wr) begin
      ram_wr      = 1'b1;
      ram_wr_addr = clr_cnt_r;
      ram_wr_data = LNK_W'(clr_cnt_r) + LNK_W'(1);
    end else begin
      ram_wr      = cmd.commit && free_wr;
      ram_wr_addr = free_idx_full[IDX_W-1:0];
      ram_wr_data = head_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= BASE_RST;
      shift_r     <= SHIFT_RST;
      head_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_BASE_ADDRESS:   base_r  <= cfg_data[ADDR_W-1:0];
          CFG_UNIT_SIZE_LOG2: shift_r <= cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      if (cmd.commit) begin
        head_r      <= head_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_op;
      size_r <= in_request_size;
      diff_r <= {1'b0, in_free_address} - {1'b0, base_r};
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
      uaddr_r  <= uaddr_nxt;
    end
  end

  assign sts.clr_last      = clr_cnt_r == LAST_IDX;
  assign sts.out_free      = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_unit_address  = uaddr_r;

endmodule

// File: hw/rtl/fufla_ctrl.sv
// ----------------------------------------------------------------------------
// fufla_ctrl
// allocator controller: clearing pass after reset, then one request at a time
// ----------------------------------------------------------------------------
module fufla_ctrl import fufla_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    in_ready_nxt = state_nxt == S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

// File: hw/rtl/fufla_checker.sv
// ----------------------------------------------------------------------------
// fufla_checker
// port-level assertions for the allocator, bound to the top level
// ----------------------------------------------------------------------------
module fufla_checker import fufla_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [ADDR_W-1:0]   out_unit_address
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_unit_address))
    else $error("result beat changed while stalled");

  // only a successful allocate carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ALLOCATED |-> out_unit_address == '0)
    else $error("nonzero address on a failed or free result");

  // status codes stay within the defined set
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_ALLOCATED || out_status == ST_TOO_LARGE
      || out_status == ST_POOL_EMPTY || out_status == ST_FREED
      || out_status == ST_OUTSIDE)
    else $error("undefined status code");

  // one request in flight: ready drops right after a taken beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is executing");

  // ready is low right after reset, when the clearing of the link table begins
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready high right after reset");

endmodule

bind fixed_unit_free_list_allocator fufla_checker u_fufla_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_unit_address (out_unit_address)
);
